// ===== rtl/fdms_pkg.sv =====
// Shared widths, codes, state encoding and control structs for the frame difference block.
package fdms_pkg;

  localparam int PIX_W       = 8;
  localparam int DIM_W       = 9;
  localparam int THR_W       = 8;
  localparam int CFG_W       = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int TOT_W       = 2 * DIM_W;
  localparam int CNT_W       = 17;
  localparam int SUM_W       = 32;
  localparam int FRM_W       = 32;
  localparam int RATIO_SHIFT = 16;
  localparam int NUM_W       = CNT_W + RATIO_SHIFT;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd2;

  localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 9'd384;
  localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 9'd288;
  localparam logic [THR_W-1:0] RST_THRESHOLD    = 8'd0;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  typedef struct packed {
    logic capture;
    logic calc;
  } dp_cmd_t;

  typedef struct packed {
    logic is_last;
    logic div_done;
  } dp_sts_t;

endpackage

// ===== rtl/fdms_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fdms_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/fdms_div.sv =====
// Restoring divider, one quotient bit per cycle, for the motion ratio.
module fdms_div
  import fdms_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [TOT_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [TOT_W-1:0]  rem_r, rem_nxt;
  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [TOT_W-1:0]  den_r, den_nxt;
  logic [TOT_W:0]    shifted;
  logic [TOT_W:0]    trial;

  assign shifted = {rem_r, quo_r[NUM_W-1]};
  assign trial   = shifted - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(NUM_W);
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      // subtract when the shifted remainder covers the divisor
      if (shifted >= {1'b0, den_r}) begin
        rem_nxt = trial[TOT_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[TOT_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== rtl/fdms_ctrl.sv =====
// Controller state machine: sequences capture, store access, ratio divide and result hold.
module fdms_ctrl
  import fdms_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        state_nxt = sts.is_last ? S_DIV : S_OUT;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = (state_r == S_OUT);
  assign cmd.capture = (state_r == S_IDLE) && in_valid;
  assign cmd.calc    = (state_r == S_CALC);

  a_accept_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_CALC)
    else $error("accepted word did not enter calc");

  a_plain_pixel_skips_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CALC && !sts.is_last |=> out_valid)
    else $error("non-final pixel did not go straight to output");

  a_div_done_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV && sts.div_done |=> out_valid)
    else $error("divider finished but result not presented");

  a_no_accept_while_holding: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");

endmodule

// ===== rtl/fdms_datapath.sv =====
// Datapath: frame store, difference, accumulators, frame counters and result registers.
module fdms_datapath
  import fdms_pkg::*;
#(
  parameter int MAX_WIDTH  = 384,
  parameter int MAX_HEIGHT = 288
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts,
  input  logic [DIM_W-1:0]  frame_width,
  input  logic [DIM_W-1:0]  frame_height,
  input  logic [THR_W-1:0]  motion_threshold,
  input  logic [PIX_W-1:0]  in_pixel,
  input  logic              in_start_of_frame,
  input  logic              in_end_of_line,
  output logic [PIX_W-1:0]  out_pixel,
  output logic              out_start_of_frame,
  output logic              out_end_of_line,
  output logic              out_frame_done,
  output logic [SUM_W-1:0]  out_difference_sum,
  output logic [CNT_W-1:0]  out_motion_pixel_count,
  output logic [CNT_W-1:0]  out_motion_ratio,
  output logic [CNT_W-1:0]  out_pixels_in_frame,
  output logic [FRM_W-1:0]  out_frame_number
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W = ((IDX_W > TOT_W) ? IDX_W : TOT_W) + 1;
  localparam int DIM_MAX = (1 << DIM_W) - 1;
  localparam logic [DIM_W-1:0] W_HI = (MAX_WIDTH > DIM_MAX) ? '1 : DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] H_HI = (MAX_HEIGHT > DIM_MAX) ? '1 : DIM_W'(MAX_HEIGHT);

  logic [DIM_W-1:0] w_eff, h_eff;
  logic [TOT_W-1:0] total_r, total_nxt;

  logic [PIX_W-1:0] pix_r;
  logic             sof_r, eol_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [SUM_W-1:0] sum_acc_r, sum_acc_nxt;
  logic [CNT_W-1:0] mot_acc_r, mot_acc_nxt;
  logic [FRM_W-1:0] frm_cnt_r, frm_cnt_nxt;

  logic [PIX_W-1:0] prev;
  logic [PIX_W-1:0] diff;
  logic [SUM_W-1:0] sum_now;
  logic [CNT_W-1:0] mot_now;
  logic [CMP_W-1:0] idx_plus;
  logic             is_last;

  logic             div_done;
  logic [NUM_W-1:0] div_quo;

  logic [PIX_W-1:0] o_pix_r;
  logic             o_sof_r, o_eol_r, o_done_r;
  logic [SUM_W-1:0] o_sum_r;
  logic [CNT_W-1:0] o_cnt_r, o_ratio_r, o_tot_r;
  logic [FRM_W-1:0] o_frm_r;

  // saturate the programmed size into the supported range
  always_comb begin
    if (frame_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (frame_width > W_HI) begin
      w_eff = W_HI;
    end else begin
      w_eff = frame_width;
    end
    if (frame_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (frame_height > H_HI) begin
      h_eff = H_HI;
    end else begin
      h_eff = frame_height;
    end
  end

  assign total_nxt = TOT_W'(w_eff) * TOT_W'(h_eff);

  fdms_ram #(
    .WIDTH  (PIX_W),
    .DEPTH  (DEPTH),
    .ADDR_W (IDX_W)
  ) u_store (
    .clk   (clk),
    .we    (cmd.calc),
    .waddr (idx_r),
    .wdata (pix_r),
    .re    (cmd.capture),
    .raddr (idx_r),
    .rdata (prev)
  );

  assign diff     = (pix_r >= prev) ? (pix_r - prev) : (prev - pix_r);
  assign sum_now  = sum_acc_r + SUM_W'(diff);
  assign mot_now  = (diff > motion_threshold) ? mot_acc_r + 1'b1 : mot_acc_r;
  assign idx_plus = CMP_W'(idx_r) + 1'b1;
  assign is_last  = (idx_plus >= CMP_W'(total_r));

  always_comb begin
    idx_nxt     = idx_r;
    sum_acc_nxt = sum_acc_r;
    mot_acc_nxt = mot_acc_r;
    frm_cnt_nxt = frm_cnt_r;
    if (cmd.calc) begin
      if (is_last) begin
        idx_nxt     = '0;
        sum_acc_nxt = '0;
        mot_acc_nxt = '0;
        frm_cnt_nxt = frm_cnt_r + 1'b1;
      end else begin
        idx_nxt     = idx_plus[IDX_W-1:0];
        sum_acc_nxt = sum_now;
        mot_acc_nxt = mot_now;
      end
    end
  end

  fdms_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.calc && is_last),
    .num   ({mot_now, RATIO_SHIFT'(0)}),
    .den   (total_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      sum_acc_r <= '0;
      mot_acc_r <= '0;
      frm_cnt_r <= '0;
    end else begin
      idx_r     <= idx_nxt;
      sum_acc_r <= sum_acc_nxt;
      mot_acc_r <= mot_acc_nxt;
      frm_cnt_r <= frm_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    total_r <= total_nxt;
    if (cmd.capture) begin
      pix_r <= in_pixel;
      sof_r <= in_start_of_frame;
      eol_r <= in_end_of_line;
    end
    if (cmd.calc) begin
      o_pix_r   <= pix_r;
      o_sof_r   <= sof_r;
      o_eol_r   <= eol_r;
      o_done_r  <= is_last;
      o_sum_r   <= is_last ? sum_now : '0;
      o_cnt_r   <= is_last ? mot_now : '0;
      o_tot_r   <= is_last ? total_r[CNT_W-1:0] : '0;
      o_frm_r   <= is_last ? frm_cnt_r + 1'b1 : '0;
      o_ratio_r <= '0;
    end else if (div_done) begin
      o_ratio_r <= div_quo[CNT_W-1:0];
    end
  end

  assign sts.is_last  = is_last;
  assign sts.div_done = div_done;

  assign out_pixel              = o_pix_r;
  assign out_start_of_frame     = o_sof_r;
  assign out_end_of_line        = o_eol_r;
  assign out_frame_done         = o_done_r;
  assign out_difference_sum     = o_sum_r;
  assign out_motion_pixel_count = o_cnt_r;
  assign out_motion_ratio       = o_ratio_r;
  assign out_pixels_in_frame    = o_tot_r;
  assign out_frame_number       = o_frm_r;

endmodule

// ===== rtl/frame_difference_motion_stats.sv =====
// Frame difference motion statistics: top level with configuration registers.
//
// Input channel in_*: one grayscale pixel word with start-of-frame and
// end-of-line flags, valid/ready. Output channel out_*: the same pixel and
// flags, plus frame statistics that are nonzero only on the word with
// out_frame_done set. Frames are counted internally as width x height pixels;
// the incoming flags are passed through and do not delimit frames.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 width,
// 1 height, 2 threshold); write only while the block is idle.
// Sequence: an accepted pixel is captured with its frame-store read, then is
// written back and its statistics registered, then is presented; the last
// pixel of a frame first goes through the bit-serial ratio divide (33 steps)
// and the hand-over of its quotient. The block takes no new pixel until the
// result is taken, since each word reads the frame store, then writes it
// back, then is held in the single result register until taken.
// Reset: size returns to 384 x 288, threshold 0, counters clear; the frame
// store keeps no reset, so the first frame's statistics are invalid.
// Stall: while out_ready is low the result holds and in_ready stays low.
module frame_difference_motion_stats
  import fdms_pkg::*;
#(
  parameter int MAX_WIDTH  = 384,
  parameter int MAX_HEIGHT = 288
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIX_W-1:0]     in_pixel,
  input  logic                 in_start_of_frame,
  input  logic                 in_end_of_line,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIX_W-1:0]     out_pixel,
  output logic                 out_start_of_frame,
  output logic                 out_end_of_line,
  output logic                 out_frame_done,
  output logic [SUM_W-1:0]     out_difference_sum,
  output logic [CNT_W-1:0]     out_motion_pixel_count,
  output logic [CNT_W-1:0]     out_motion_ratio,
  output logic [CNT_W-1:0]     out_pixels_in_frame,
  output logic [FRM_W-1:0]     out_frame_number
);

  logic [DIM_W-1:0] width_r, width_nxt;
  logic [DIM_W-1:0] height_r, height_nxt;
  logic [THR_W-1:0] thr_r, thr_nxt;
  dp_cmd_t          cmd;
  dp_sts_t          sts;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    thr_nxt    = thr_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  width_nxt  = cfg_data[DIM_W-1:0];
        CFG_FRAME_HEIGHT: height_nxt = cfg_data[DIM_W-1:0];
        CFG_THRESHOLD:    thr_nxt    = cfg_data[THR_W-1:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_FRAME_WIDTH;
      height_r <= RST_FRAME_HEIGHT;
      thr_r    <= RST_THRESHOLD;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      thr_r    <= thr_nxt;
    end
  end

  fdms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  fdms_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .frame_width            (width_r),
    .frame_height           (height_r),
    .motion_threshold       (thr_r),
    .in_pixel               (in_pixel),
    .in_start_of_frame      (in_start_of_frame),
    .in_end_of_line         (in_end_of_line),
    .out_pixel              (out_pixel),
    .out_start_of_frame     (out_start_of_frame),
    .out_end_of_line        (out_end_of_line),
    .out_frame_done         (out_frame_done),
    .out_difference_sum     (out_difference_sum),
    .out_motion_pixel_count (out_motion_pixel_count),
    .out_motion_ratio       (out_motion_ratio),
    .out_pixels_in_frame    (out_pixels_in_frame),
    .out_frame_number       (out_frame_number)
  );

endmodule
